[sv/ris_pkg.sv]
// ----------------------------------------------------------------------------
// ris_pkg
// Types and constants shared by the roller intake sequencer modules.
// ----------------------------------------------------------------------------
package ris_pkg;

  localparam int CurW  = 15;  // motor current, 0.01 A units
  localparam int MvW   = 15;  // signed millivolts
  localparam int TickW = 16;  // pickup countdown load value
  localparam int CntW  = 17;  // signed pickup countdown
  localparam int GoalW = 3;
  localparam int IdxW  = 3;   // register index

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_INTAKING  = 3'd1,
    MODE_PICKING   = 3'd2,
    MODE_CARRYING  = 3'd3,
    MODE_SCORING   = 3'd4,
    MODE_OUTTAKING = 3'd5
  } mode_t;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_GOAL = 1'b1;

  localparam logic [GoalW-1:0] GOAL_DROP    = 3'd0;
  localparam logic [GoalW-1:0] GOAL_RISE    = 3'd1;
  localparam logic [GoalW-1:0] GOAL_SCORE   = 3'd2;
  localparam logic [GoalW-1:0] GOAL_NONE    = 3'd3;
  localparam logic [GoalW-1:0] GOAL_OUTTAKE = 3'd4;

  localparam logic [IdxW-1:0] REG_INTAKE_MV  = 3'd0;
  localparam logic [IdxW-1:0] REG_PICKUP_MV  = 3'd1;
  localparam logic [IdxW-1:0] REG_CARRY_MV   = 3'd2;
  localparam logic [IdxW-1:0] REG_SCORE_MV   = 3'd3;
  localparam logic [IdxW-1:0] REG_OUTTAKE_MV = 3'd4;
  localparam logic [IdxW-1:0] REG_THRESHOLD  = 3'd5;
  localparam logic [IdxW-1:0] REG_TICKS      = 3'd6;

  localparam logic [CurW-1:0]        THRESHOLD_RESET = 15'd20000;
  localparam logic signed [CntW-1:0] COUNT_MIN       = 17'sh10000;

  typedef struct packed {
    logic signed [MvW-1:0] intake_drive_mv;
    logic signed [MvW-1:0] pickup_drive_mv;
    logic signed [MvW-1:0] carry_drive_mv;
    logic signed [MvW-1:0] score_drive_mv;
    logic signed [MvW-1:0] outtake_drive_mv;
    logic [CurW-1:0]       spike_threshold;
    logic [TickW-1:0]      pickup_ticks;
  } cfg_t;

  typedef struct packed {
    logic             op;
    logic [CurW-1:0]  motor_current;
    logic             drive_enabled;
    logic [GoalW-1:0] goal_code;
  } item_t;

  typedef struct packed {
    logic signed [MvW-1:0] roller_mv;
    logic                  arm_down;
    logic                  spike_seen;
    logic [2:0]            mode_code;
    logic                  roller_off;
  } result_t;

endpackage

[sv/ris_regs.sv]
// ----------------------------------------------------------------------------
// ris_regs
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
module ris_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output ris_pkg::cfg_t cfg
);

  logic [ris_pkg::IdxW-1:0] idx;
  logic                     wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.intake_drive_mv  <= '0;
      cfg.pickup_drive_mv  <= '0;
      cfg.carry_drive_mv   <= '0;
      cfg.score_drive_mv   <= '0;
      cfg.outtake_drive_mv <= '0;
      cfg.spike_threshold  <= ris_pkg::THRESHOLD_RESET;
      cfg.pickup_ticks     <= '0;
    end else if (wr_en) begin
      unique case (idx)
        ris_pkg::REG_INTAKE_MV:  cfg.intake_drive_mv  <= pwdata[ris_pkg::MvW-1:0];
        ris_pkg::REG_PICKUP_MV:  cfg.pickup_drive_mv  <= pwdata[ris_pkg::MvW-1:0];
        ris_pkg::REG_CARRY_MV:   cfg.carry_drive_mv   <= pwdata[ris_pkg::MvW-1:0];
        ris_pkg::REG_SCORE_MV:   cfg.score_drive_mv   <= pwdata[ris_pkg::MvW-1:0];
        ris_pkg::REG_OUTTAKE_MV: cfg.outtake_drive_mv <= pwdata[ris_pkg::MvW-1:0];
        ris_pkg::REG_THRESHOLD:  cfg.spike_threshold  <= pwdata[ris_pkg::CurW-1:0];
        ris_pkg::REG_TICKS:      cfg.pickup_ticks     <= pwdata[ris_pkg::TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      ris_pkg::REG_INTAKE_MV:  prdata = {17'd0, cfg.intake_drive_mv};
      ris_pkg::REG_PICKUP_MV:  prdata = {17'd0, cfg.pickup_drive_mv};
      ris_pkg::REG_CARRY_MV:   prdata = {17'd0, cfg.carry_drive_mv};
      ris_pkg::REG_SCORE_MV:   prdata = {17'd0, cfg.score_drive_mv};
      ris_pkg::REG_OUTTAKE_MV: prdata = {17'd0, cfg.outtake_drive_mv};
      ris_pkg::REG_THRESHOLD:  prdata = {17'd0, cfg.spike_threshold};
      ris_pkg::REG_TICKS:      prdata = {16'd0, cfg.pickup_ticks};
      default:                 prdata = '0;
    endcase
  end

endmodule

[sv/ris_core.sv]
// ----------------------------------------------------------------------------
// ris_core
// Mode and countdown state with the single-step update and result logic.
// ----------------------------------------------------------------------------
module ris_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  ris_pkg::item_t   item,
  input  ris_pkg::cfg_t    cfg,
  output ris_pkg::result_t res
);

  ris_pkg::mode_t                     mode, mode_next;
  logic signed [ris_pkg::CntW-1:0]    pickup_count, pickup_count_next;
  logic signed [ris_pkg::CntW-1:0]    count_dec;
  logic signed [ris_pkg::MvW-1:0]     mv;
  logic                               arm;
  logic                               spike;

  // The countdown sticks at its floor instead of wrapping.
  assign count_dec = (pickup_count != ris_pkg::COUNT_MIN) ?
                     pickup_count - 17'sd1 : pickup_count;

  always_comb begin
    mode_next         = mode;
    pickup_count_next = pickup_count;
    mv                = '0;
    arm               = 1'b0;
    spike             = 1'b0;
    if (item.op == ris_pkg::OP_GOAL) begin
      unique case (item.goal_code)
        ris_pkg::GOAL_DROP: mode_next = ris_pkg::MODE_INTAKING;
        ris_pkg::GOAL_RISE: begin
          if (mode == ris_pkg::MODE_INTAKING) mode_next = ris_pkg::MODE_IDLE;
        end
        ris_pkg::GOAL_SCORE: begin
          if (mode == ris_pkg::MODE_CARRYING || mode == ris_pkg::MODE_IDLE)
            mode_next = ris_pkg::MODE_SCORING;
        end
        ris_pkg::GOAL_NONE: begin
          if (mode == ris_pkg::MODE_SCORING) mode_next = ris_pkg::MODE_IDLE;
        end
        ris_pkg::GOAL_OUTTAKE: mode_next = ris_pkg::MODE_OUTTAKING;
        default: ;
      endcase
    end else if (item.drive_enabled) begin
      unique case (mode)
        ris_pkg::MODE_INTAKING: begin
          mv  = cfg.intake_drive_mv;
          arm = 1'b1;
          if (item.motor_current > cfg.spike_threshold) begin
            spike             = 1'b1;
            mode_next         = ris_pkg::MODE_PICKING;
            pickup_count_next = signed'({1'b0, cfg.pickup_ticks});
            mv                = cfg.pickup_drive_mv;
          end
        end
        ris_pkg::MODE_PICKING: begin
          mv                = cfg.pickup_drive_mv;
          pickup_count_next = count_dec;
          if (count_dec[ris_pkg::CntW-1]) mode_next = ris_pkg::MODE_CARRYING;
        end
        ris_pkg::MODE_CARRYING:  mv = cfg.carry_drive_mv;
        ris_pkg::MODE_SCORING:   mv = cfg.score_drive_mv;
        ris_pkg::MODE_OUTTAKING: mv = cfg.outtake_drive_mv;
        default: ;
      endcase
    end
  end

  always_comb begin
    res.roller_mv  = mv;
    res.arm_down   = arm;
    res.spike_seen = spike;
    res.mode_code  = mode_next;
    res.roller_off = (mv == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= ris_pkg::MODE_IDLE;
      pickup_count <= '0;
    end else if (adv) begin
      mode         <= mode_next;
      pickup_count <= pickup_count_next;
    end
  end

  a_spike_loads: assert property (@(posedge clk) disable iff (rst)
    adv && item.op == ris_pkg::OP_TICK && item.drive_enabled &&
    mode == ris_pkg::MODE_INTAKING && item.motor_current > cfg.spike_threshold
    |=> mode == ris_pkg::MODE_PICKING &&
        pickup_count == signed'({1'b0, $past(cfg.pickup_ticks)}))
    else $error("spike did not start pickup with a loaded countdown");

  a_disabled_hold: assert property (@(posedge clk) disable iff (rst)
    adv && item.op == ris_pkg::OP_TICK && !item.drive_enabled
    |=> $stable(mode) && $stable(pickup_count))
    else $error("disabled tick moved the sequencer state");

  a_goal_keeps_count: assert property (@(posedge clk) disable iff (rst)
    adv && item.op == ris_pkg::OP_GOAL |=> $stable(pickup_count))
    else $error("goal command changed the pickup countdown");

  a_carry_after_count: assert property (@(posedge clk) disable iff (rst)
    adv && item.op == ris_pkg::OP_TICK && item.drive_enabled &&
    mode == ris_pkg::MODE_PICKING && !count_dec[ris_pkg::CntW-1]
    |=> mode == ris_pkg::MODE_PICKING)
    else $error("pickup ended while the countdown was not negative");

endmodule

[sv/roller_intake_sequencer.sv]
// ----------------------------------------------------------------------------
// roller_intake_sequencer
// Six-mode roller intake sequencer with a stream input, a stream output and
// an APB-style configuration port.
// ----------------------------------------------------------------------------
// Path: a tick transfer goes through one input register and one result
// register before it is presented on m_tvalid.
// Throughput: one item per cycle; goal commands and ticks can follow each
// other back to back, limited only by m_tready on the result register.
// Reset: synchronous, active high; mode returns to idle, the countdown to
// zero, drives to 0 mV and the spike threshold to 20000.
// ----------------------------------------------------------------------------
module roller_intake_sequencer (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, low bit up: motor_current[14:0], drive_enabled[15],
  // goal_code[18:16], zero fill [23:19].
  input  logic [23:0] s_tdata,
  // s_tuser: op[0] (0 control tick, 1 goal command).
  input  logic [0:0]  s_tuser,
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, low bit up: roller_mv[14:0], arm_down[15], spike_seen[16],
  // mode_code[19:17], roller_off[20], zero fill [23:21].
  output logic [23:0] m_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ris_pkg::cfg_t    cfg;
  ris_pkg::item_t   in_item;
  logic             in_valid;
  logic             in_adv;
  ris_pkg::result_t step_res;
  ris_pkg::result_t out_res;
  logic             out_valid;

  ris_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // An item in the input register moves on when it is a goal command, which
  // produces no result, or when the result register is free or is being
  // emptied in this cycle. The sequencer state is updated at that same edge,
  // so items take effect strictly in arrival order.
  assign in_adv   = in_valid &&
                    (in_item.op == ris_pkg::OP_GOAL || !out_valid || m_tready);
  assign s_tready = !in_valid || in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // The payload needs no reset; it is only looked at while in_valid is set.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op            <= s_tuser[0];
      in_item.motor_current <= s_tdata[14:0];
      in_item.drive_enabled <= s_tdata[15];
      in_item.goal_code     <= s_tdata[18:16];
    end
  end

  ris_core u_core (
    .clk  (clk),
    .rst  (rst),
    .adv  (in_adv),
    .item (in_item),
    .cfg  (cfg),
    .res  (step_res)
  );

  // Result register: it holds a finished result while the next item is
  // already being taken into the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_adv && in_item.op == ris_pkg::OP_TICK) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_item.op == ris_pkg::OP_TICK) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, out_res.roller_off, out_res.mode_code,
                     out_res.spike_seen, out_res.arm_down, out_res.roller_mv};

endmodule
